@@ src/bpc_pkg.sv @@
// ---------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier.
// ---------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int EV_W        = 2;
    localparam int TIME_W      = 32;
    localparam int TICKS_W     = 4;
    localparam int MS_W        = 16;
    localparam int SEL_W       = 3;
    localparam int IN_W        = 40;
    localparam int OUT_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TICKS_W-1:0] DEBOUNCE_RST = 4'd4;
    localparam logic [MS_W-1:0]    LONG_RST     = 16'd800;
    localparam logic [MS_W-1:0]    WINDOW_RST   = 16'd450;
    localparam logic [SEL_W-1:0]   DBL_BTN_RST  = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DBL_BTN  = 2'd3;

    typedef enum logic [EV_W-1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } event_t;

    typedef struct packed {
        logic [TICKS_W-1:0] debounce_ticks;
        logic [MS_W-1:0]    long_press_ms;
        logic [MS_W-1:0]    double_window_ms;
    } cfg_t;

    typedef struct packed {
        event_t ev;
        logic   armed_next;
    } lane_res_t;

endpackage

`default_nettype wire

@@ src/button_press_classifier.sv @@
// ---------------------------------------------------------------------------
// button_press_classifier
// Debounces five buttons and reports short, long and double presses.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis: one word per poll tick, tdata = {pad, now_ms[31:0], pressed_bits[4:0]}.
//   m_axis: one word per accepted tick, tdata = {pad, event_b4 .. event_b0},
//           2 bits per button: 0 none, 1 short, 2 long, 3 double.
//   cfg: index 0 debounce_ticks, 1 long_press_ms, 2 double_window_ms,
//        3 double_button; write only while idle, always ready.
// Output: the result word is registered and appears in the cycle after the tick is accepted.
// Throughput: one tick per cycle unless stalled; all five lanes evaluate in parallel
//   and the merge stage registers the result word and the shared double arm.
// Stall: the output register holds its word while m_axis_tready is low;
//   s_axis_tready stays high while that word is taken in the same cycle.
// Reset: all counters, flags, stamps and the arm clear; registers return to
//   4 ticks, 800 ms, 450 ms, button 4.
// ---------------------------------------------------------------------------
`default_nettype none

module button_press_classifier
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [bpc_pkg::IN_W-1:0]           s_axis_tdata,  // pressed_bits, now_ms
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [bpc_pkg::OUT_W-1:0]               m_axis_tdata,  // event_b0..event_b4
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bpc_pkg::cfg_t                        cfg_reg;
    logic [bpc_pkg::SEL_W-1:0]            dbl_btn_reg;
    logic [bpc_pkg::NUM_BUTTONS-1:0]      pressed;
    logic [bpc_pkg::TIME_W-1:0]           now_ms;
    logic [bpc_pkg::NUM_BUTTONS-1:0]      sel;
    logic [bpc_pkg::NUM_BUTTONS-1:0]      dbl_hits;
    logic                                 accept;
    logic                                 armed;
    bpc_pkg::lane_res_t                   res [bpc_pkg::NUM_BUTTONS];

    assign pressed   = s_axis_tdata[bpc_pkg::NUM_BUTTONS-1:0];
    assign now_ms    = s_axis_tdata[bpc_pkg::NUM_BUTTONS +: bpc_pkg::TIME_W];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= bpc_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ms    <= bpc_pkg::LONG_RST;
            cfg_reg.double_window_ms <= bpc_pkg::WINDOW_RST;
            dbl_btn_reg              <= bpc_pkg::DBL_BTN_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                bpc_pkg::CFG_DEBOUNCE: cfg_reg.debounce_ticks   <= cfg_data[bpc_pkg::TICKS_W-1:0];
                bpc_pkg::CFG_LONG:     cfg_reg.long_press_ms    <= cfg_data;
                bpc_pkg::CFG_WINDOW:   cfg_reg.double_window_ms <= cfg_data;
                bpc_pkg::CFG_DBL_BTN:  dbl_btn_reg              <= cfg_data[bpc_pkg::SEL_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < bpc_pkg::NUM_BUTTONS; i++)
    begin : g_lane
        assign sel[i]      = (dbl_btn_reg == bpc_pkg::SEL_W'(i));
        assign dbl_hits[i] = (res[i].ev == bpc_pkg::EV_DOUBLE);

        bpc_lane u_lane
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (accept),
            .raw     (pressed[i]),
            .now_ms  (now_ms),
            .cfg     (cfg_reg),
            .is_dbl  (sel[i]),
            .armed   (armed),
            .res     (res[i])
        );
    end

    bpc_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .accept    (accept),
        .res       (res),
        .sel       (sel),
        .armed     (armed),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    a_arm_needs_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (sel == '0) |=> $stable(armed))
        else $error("double arm changed with no double button selected");

    a_dbl_only_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (dbl_hits & ~sel) == '0)
        else $error("double press on an unselected button");

    a_dbl_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(dbl_hits))
        else $error("more than one double press in a word");

    a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted tick produced no output word");

endmodule

`default_nettype wire

@@ src/bpc_lane.sv @@
// ---------------------------------------------------------------------------
// bpc_lane
// Per-button debounce counter, hold timing and short/long/double detection.
// ---------------------------------------------------------------------------
`default_nettype none

module bpc_lane
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               advance,
    input  wire logic                               raw,
    input  wire logic [bpc_pkg::TIME_W-1:0]         now_ms,
    input  wire bpc_pkg::cfg_t                      cfg,
    input  wire logic                               is_dbl,
    input  wire logic                               armed,
    output bpc_pkg::lane_res_t                      res
);

    logic [bpc_pkg::TICKS_W-1:0] count_reg, count_next;
    logic                        held_reg, held_next;
    logic                        reported_reg, reported_next;
    logic [bpc_pkg::TIME_W-1:0]  stamp_reg, stamp_next;

    logic [bpc_pkg::TIME_W-1:0]  diff;
    logic [bpc_pkg::TIME_W-1:0]  hold_diff;
    logic                        restamp;
    logic                        armed_mid;
    bpc_pkg::event_t             ev;

    always_comb
    begin
        diff          = now_ms - stamp_reg;
        count_next    = count_reg;
        held_next     = held_reg;
        reported_next = reported_reg;
        restamp       = 1'b0;
        armed_mid     = armed;
        ev            = bpc_pkg::EV_NONE;
        hold_diff     = diff;
        if (raw)
        begin
            if (count_reg < cfg.debounce_ticks)
            begin
                count_next = count_reg + 4'd1;
            end
            if ((count_next >= cfg.debounce_ticks) && !held_reg)
            begin
                held_next     = 1'b1;
                restamp       = 1'b1;
                reported_next = 1'b0;
                hold_diff     = '0;
            end
            if (held_next && !reported_next &&
                (hold_diff >= {16'd0, cfg.long_press_ms}))
            begin
                ev            = bpc_pkg::EV_LONG;
                reported_next = 1'b1;
            end
        end
        else
        begin
            if (count_reg != '0)
            begin
                count_next = count_reg - 4'd1;
            end
            if (held_reg && (count_next == '0))
            begin
                held_next = 1'b0;
                if (!reported_reg)
                begin
                    if (is_dbl && armed && (diff <= {16'd0, cfg.double_window_ms}))
                    begin
                        ev        = bpc_pkg::EV_DOUBLE;
                        armed_mid = 1'b0;
                    end
                    else
                    begin
                        ev = bpc_pkg::EV_SHORT;
                        if (is_dbl)
                        begin
                            armed_mid = 1'b1;
                            restamp   = 1'b1;
                        end
                    end
                end
            end
        end
        // window expiry; a fresh stamp gives zero elapsed time
        if (is_dbl && armed_mid && !restamp && (diff > {16'd0, cfg.double_window_ms}))
        begin
            armed_mid = 1'b0;
        end
        stamp_next = restamp ? now_ms : stamp_reg;
    end

    assign res.ev         = ev;
    assign res.armed_next = armed_mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            held_reg     <= 1'b0;
            reported_reg <= 1'b0;
            stamp_reg    <= '0;
        end
        else if (advance)
        begin
            count_reg    <= count_next;
            held_reg     <= held_next;
            reported_reg <= reported_next;
            stamp_reg    <= stamp_next;
        end
    end

endmodule

`default_nettype wire

@@ src/bpc_merge.sv @@
// ---------------------------------------------------------------------------
// bpc_merge
// Collects lane events into the output word and keeps the shared double arm.
// ---------------------------------------------------------------------------
`default_nettype none

module bpc_merge
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    output logic                                     accept,
    input  wire bpc_pkg::lane_res_t                  res [bpc_pkg::NUM_BUTTONS],
    input  wire logic [bpc_pkg::NUM_BUTTONS-1:0]     sel,
    output logic                                     armed,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [bpc_pkg::OUT_W-1:0]                out_data
);

    localparam int EVS_W = bpc_pkg::NUM_BUTTONS * bpc_pkg::EV_W;

    logic             armed_reg, armed_next;
    logic             valid_reg;
    logic [EVS_W-1:0] events_reg, events_next;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        armed_next = armed_reg;
        for (int i = 0; i < bpc_pkg::NUM_BUTTONS; i++)
        begin
            events_next[i*bpc_pkg::EV_W +: bpc_pkg::EV_W] = res[i].ev;
            if (sel[i])
            begin
                armed_next = res[i].armed_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            armed_reg <= armed_next;
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            events_reg <= events_next;
        end
    end

    assign armed     = armed_reg;
    assign out_valid = valid_reg;
    assign out_data  = {{(bpc_pkg::OUT_W - EVS_W){1'b0}}, events_reg};

endmodule

`default_nettype wire
